// ===== rtl/hrep_pkg.sv =====
`timescale 1ns / 1ps
// Package for the hash ring endpoint picker: sizes, codes and beat types.
// No dependencies; every other file imports it.
package hrep_pkg;

    localparam int RING_DEPTH    = 4096;
    localparam int MAX_ENDPOINTS = 256;
    localparam int SLOT_W        = $clog2(RING_DEPTH);
    localparam int EP_W          = $clog2(MAX_ENDPOINTS);
    localparam int RING_LEN_W    = SLOT_W + 1;
    localparam int EP_LEN_W      = EP_W + 1;
    localparam int HASH_W        = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 13;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RING_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EP_LEN   = 2'd1;

    // request types
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_STATE   = 2'd1;
    localparam logic [1:0] REQ_PICK    = 2'd2;
    localparam logic [1:0] REQ_REEVAL  = 2'd3;

    // result kinds
    localparam logic [1:0] RES_ACK     = 2'd0;
    localparam logic [1:0] RES_PICK    = 2'd1;
    localparam logic [1:0] RES_AGG     = 2'd2;

    // pick outcomes
    localparam logic [1:0] PICK_USE     = 2'd0;
    localparam logic [1:0] PICK_QUEUE   = 2'd1;
    localparam logic [1:0] PICK_CONNECT = 2'd2;
    localparam logic [1:0] PICK_FAIL    = 2'd3;

    // connection states
    localparam logic [1:0] ST_IDLE       = 2'd0;
    localparam logic [1:0] ST_CONNECTING = 2'd1;
    localparam logic [1:0] ST_READY      = 2'd2;
    localparam logic [1:0] ST_TFAIL      = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [SLOT_W-1:0] ring_slot;
        logic [HASH_W-1:0] entry_hash;
        logic [EP_W-1:0]   entry_endpoint;
        logic [EP_W-1:0]   changed_endpoint;
        logic [1:0]        new_conn_state;
        logic [HASH_W-1:0] lookup_hash;
    } req_t;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [1:0]        pick_outcome;
        logic [EP_W-1:0]   picked_endpoint;
        logic [SLOT_W-1:0] start_position;
        logic [1:0]        aggregate_state;
        logic              connect_request;
        logic [EP_W-1:0]   connect_endpoint;
    } res_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] wdata;
    } cfg_t;

endpackage

// ===== rtl/hrep_if.sv =====
`timescale 1ns / 1ps
// Handshake interfaces for request, result and configuration beats.
// Depends on hrep_pkg.
interface hrep_req_if
    import hrep_pkg::*;
;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hrep_res_if
    import hrep_pkg::*;
;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hrep_cfg_if
    import hrep_pkg::*;
;
    logic valid;
    logic ready;
    cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/hash_ring_endpoint_picker.sv =====
`timescale 1ns / 1ps
// Top level of the consistent-hash ring endpoint picker.
// Depends on hrep_pkg and the interfaces in hrep_if.
//
// cfg : register writes (index 0 ring entries in use, 1 endpoints in use),
//       always ready; write only while no item is in flight.
// req : one beat per item (load entry, state change, pick, re-evaluate),
//       ready only while the sequencer is idle, so one item at a time.
// res : exactly one result beat per request beat, held in an output register.
// Steps per request beat, with m endpoints in use:
//   load, ignored state change, empty-ring pick: straight to the result.
//   pick: a binary search that reads each probe and the entry before it,
//     then a walk from the hit (slot 0 on a wrap) reading each owner and state.
//   re-evaluate: a sweep of the m endpoints; state change: read and write first.
// The next request beat can be taken in the same cycle as the result goes
// valid, so one item at a time.
// Reset clears the sequencer, both registers and every endpoint to idle
// through per-entry valid bits; ring contents are undefined until loaded.
// A stalled receiver holds the result; the next item may still run and then
// waits in the sequencer until the output register frees.
module hash_ring_endpoint_picker
    import hrep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hrep_cfg_if.sink   cfg,
    hrep_req_if.sink   req,
    hrep_res_if.source res
);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_MID, S_SRCH_PREV, S_SRCH_CMP,
        S_WALK_OWN, S_WALK_ST, S_WALK_CHK,
        S_SC_RD, S_SC_WR, S_AGG, S_OUT
    } state_t;

    // ---------------------------------------------------------------
    // storage
    // ---------------------------------------------------------------
    logic [HASH_W-1:0] hash_mem [RING_DEPTH];
    logic [EP_W-1:0]   owner_mem [RING_DEPTH];
    logic [1:0]        conn_mem [MAX_ENDPOINTS];
    logic [MAX_ENDPOINTS-1:0] conn_valid_reg;

    logic [SLOT_W-1:0] hash_addr, owner_addr;
    logic [EP_W-1:0]   conn_addr;
    logic [HASH_W-1:0] hash_rd_q;
    logic [EP_W-1:0]   owner_rd_q;
    logic [1:0]        conn_rd_q;
    logic              conn_vld_q;
    logic              load_we, conn_we;

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    state_t state_reg, state_next;
    logic [RING_LEN_W-1:0] ring_len_reg;
    logic [EP_LEN_W-1:0]   ep_len_reg;

    logic signed [SLOT_W+1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [SLOT_W-1:0] mid_reg, mid_next;
    logic [HASH_W-1:0] h_reg, h_next, mv_reg, mv_next;

    logic [SLOT_W-1:0]     slot_reg, slot_next, start_reg, start_next;
    logic [RING_LEN_W-1:0] wcnt_reg, wcnt_next;
    logic [EP_W-1:0]       start_own_reg, start_own_next, own_reg, own_next;

    logic [EP_W-1:0] ep_reg, ep_next;
    logic [1:0]      ns_reg, ns_next;
    logic            entered_reg, entered_next;

    logic [EP_LEN_W-1:0] agg_cnt_reg, agg_cnt_next;
    logic                pend_reg, pend_next;
    logic [EP_W-1:0]     pidx_reg, pidx_next;
    logic any_ready_reg, any_ready_next, any_conn_reg, any_conn_next;
    logic any_idle_reg, any_idle_next;
    logic [1:0] tf_cnt_reg, tf_cnt_next;
    logic [EP_W-1:0] first_idle_reg, first_idle_next;

    res_t res_pend_reg, res_pend_next;
    res_t out_reg;
    logic out_valid_reg;

    // working signals
    logic [SLOT_W+2:0] mid_sum;
    logic [SLOT_W+1:0] mid_w;
    logic [HASH_W-1:0] mv1;
    logic [1:0] cur_st;
    logic [RING_LEN_W-1:0] wcnt_inc;
    logic [RING_LEN_W-1:0] slot_inc;
    logic [CFG_DATA_W-1:0] ep_val;
    logic [1:0] agg_st;
    logic agg_att;
    logic out_free;
    res_t res_zero;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;
    assign out_free  = !out_valid_reg || res.ready;
    assign res_zero  = '0;

    // state read with the reset value for entries never written
    assign cur_st = conn_vld_q ? conn_rd_q : ST_IDLE;

    assign load_we = req.valid && req.ready && (req.data.req_type == REQ_LOAD);
    assign conn_we = (state_reg == S_SC_WR);

    assign mid_sum  = (SLOT_W+3)'(lo_reg) + (SLOT_W+3)'(hi_reg);
    assign mid_w    = mid_sum[SLOT_W+2:1];
    assign mv1      = (mid_reg == '0) ? '0 : hash_rd_q;
    assign wcnt_inc = wcnt_reg + 1'b1;
    assign slot_inc = {1'b0, slot_reg} + 1'b1;
    assign ep_val   = {4'd0, cfg.data.wdata[EP_LEN_W-1:0]};

    // ---------------------------------------------------------------
    // memories: one write and one registered read port each
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            hash_mem[req.data.ring_slot]  <= req.data.entry_hash;
            owner_mem[req.data.ring_slot] <= req.data.entry_endpoint;
        end
        hash_rd_q  <= hash_mem[hash_addr];
        owner_rd_q <= owner_mem[owner_addr];
    end

    always_ff @(posedge clk)
    begin
        if (conn_we)
        begin
            conn_mem[ep_reg] <= ns_reg;
        end
        conn_rd_q  <= conn_mem[conn_addr];
        conn_vld_q <= conn_valid_reg[conn_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_valid_reg <= '0;
        end
        else if (conn_we)
        begin
            conn_valid_reg[ep_reg] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // aggregate rules on the swept counts
    // ---------------------------------------------------------------
    always_comb
    begin
        agg_st  = ST_TFAIL;
        agg_att = 1'b1;
        if (any_ready_reg)
        begin
            agg_st  = ST_READY;
            agg_att = 1'b0;
        end
        else if (tf_cnt_reg == 2'd2)
        begin
            agg_st  = ST_TFAIL;
            agg_att = 1'b1;
        end
        else if (any_conn_reg)
        begin
            agg_st  = ST_CONNECTING;
            agg_att = 1'b0;
        end
        else if (tf_cnt_reg == 2'd1 && ep_len_reg > EP_LEN_W'(1))
        begin
            agg_st  = ST_CONNECTING;
            agg_att = 1'b1;
        end
        else if (any_idle_reg)
        begin
            agg_st  = ST_IDLE;
            agg_att = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        h_next          = h_reg;
        mv_next         = mv_reg;
        slot_next       = slot_reg;
        start_next      = start_reg;
        wcnt_next       = wcnt_reg;
        start_own_next  = start_own_reg;
        own_next        = own_reg;
        ep_next         = ep_reg;
        ns_next         = ns_reg;
        entered_next    = entered_reg;
        agg_cnt_next    = agg_cnt_reg;
        pend_next       = 1'b0;
        pidx_next       = pidx_reg;
        any_ready_next  = any_ready_reg;
        any_conn_next   = any_conn_reg;
        any_idle_next   = any_idle_reg;
        tf_cnt_next     = tf_cnt_reg;
        first_idle_next = first_idle_reg;
        res_pend_next   = res_pend_reg;
        hash_addr       = mid_reg;
        owner_addr      = slot_reg;
        conn_addr       = ep_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_pend_next = res_zero;
                    // clear sweep counters for any aggregate
                    agg_cnt_next    = '0;
                    any_ready_next  = 1'b0;
                    any_conn_next   = 1'b0;
                    any_idle_next   = 1'b0;
                    tf_cnt_next     = 2'd0;
                    first_idle_next = '0;
                    entered_next    = 1'b0;
                    case (req.data.req_type)
                        REQ_LOAD:
                        begin
                            state_next = S_OUT;
                        end
                        REQ_STATE:
                        begin
                            ep_next = req.data.changed_endpoint;
                            ns_next = req.data.new_conn_state;
                            if ({1'b0, req.data.changed_endpoint} < ep_len_reg)
                            begin
                                state_next = S_SC_RD;
                            end
                            else
                            begin
                                state_next = S_OUT;
                            end
                        end
                        REQ_PICK:
                        begin
                            res_pend_next.result_kind = RES_PICK;
                            h_next = req.data.lookup_hash;
                            if (ring_len_reg == '0)
                            begin
                                res_pend_next.pick_outcome = PICK_FAIL;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = (SLOT_W+2)'(ring_len_reg);
                                state_next = S_SRCH_MID;
                            end
                        end
                        default:
                        begin
                            state_next = S_AGG;
                        end
                    endcase
                end
            end

            S_SRCH_MID:
            begin
                if (mid_w >= (SLOT_W+2)'(ring_len_reg))
                begin
                    // ran off the end: start at slot 0
                    start_next = '0;
                    slot_next  = '0;
                    wcnt_next  = '0;
                    state_next = S_WALK_OWN;
                end
                else
                begin
                    hash_addr  = mid_w[SLOT_W-1:0];
                    mid_next   = mid_w[SLOT_W-1:0];
                    state_next = S_SRCH_PREV;
                end
            end

            S_SRCH_PREV:
            begin
                mv_next    = hash_rd_q;
                hash_addr  = mid_reg - 1'b1;
                state_next = S_SRCH_CMP;
            end

            S_SRCH_CMP:
            begin
                if (h_reg <= mv_reg && h_reg > mv1)
                begin
                    start_next = mid_reg;
                    slot_next  = mid_reg;
                    wcnt_next  = '0;
                    state_next = S_WALK_OWN;
                end
                else
                begin
                    if (mv_reg < h_reg)
                    begin
                        lo_next = $signed({2'b00, mid_reg}) + (SLOT_W+2)'(1);
                    end
                    else
                    begin
                        hi_next = $signed({2'b00, mid_reg}) - (SLOT_W+2)'(1);
                    end
                    if (lo_next > hi_next)
                    begin
                        start_next = '0;
                        slot_next  = '0;
                        wcnt_next  = '0;
                        state_next = S_WALK_OWN;
                    end
                    else
                    begin
                        state_next = S_SRCH_MID;
                    end
                end
            end

            S_WALK_OWN:
            begin
                owner_addr = slot_reg;
                state_next = S_WALK_ST;
            end

            S_WALK_ST:
            begin
                if (wcnt_reg == '0)
                begin
                    start_own_next = owner_rd_q;
                end
                own_next  = owner_rd_q;
                conn_addr = owner_rd_q;
                if ({1'b0, owner_rd_q} >= ep_len_reg)
                begin
                    // owner outside the list: skip the entry
                    wcnt_next = wcnt_inc;
                    slot_next = (slot_inc == ring_len_reg) ? '0 : slot_inc[SLOT_W-1:0];
                    if (wcnt_inc == ring_len_reg)
                    begin
                        res_pend_next.pick_outcome    = PICK_FAIL;
                        res_pend_next.picked_endpoint =
                            (wcnt_reg == '0) ? owner_rd_q : start_own_reg;
                        res_pend_next.start_position  = start_reg;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_WALK_OWN;
                    end
                end
                else
                begin
                    state_next = S_WALK_CHK;
                end
            end

            S_WALK_CHK:
            begin
                res_pend_next.start_position = start_reg;
                if (cur_st != ST_TFAIL)
                begin
                    case (cur_st)
                        ST_READY:      res_pend_next.pick_outcome = PICK_USE;
                        ST_CONNECTING: res_pend_next.pick_outcome = PICK_QUEUE;
                        default:       res_pend_next.pick_outcome = PICK_CONNECT;
                    endcase
                    res_pend_next.picked_endpoint = own_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    wcnt_next = wcnt_inc;
                    slot_next = (slot_inc == ring_len_reg) ? '0 : slot_inc[SLOT_W-1:0];
                    if (wcnt_inc == ring_len_reg)
                    begin
                        res_pend_next.pick_outcome    = PICK_FAIL;
                        res_pend_next.picked_endpoint = start_own_reg;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_WALK_OWN;
                    end
                end
            end

            S_SC_RD:
            begin
                conn_addr  = ep_reg;
                state_next = S_SC_WR;
            end

            S_SC_WR:
            begin
                entered_next = (cur_st != ST_TFAIL) && (ns_reg == ST_TFAIL);
                state_next   = S_AGG;
            end

            S_AGG:
            begin
                conn_addr = agg_cnt_reg[EP_W-1:0];
                if (agg_cnt_reg < ep_len_reg)
                begin
                    pend_next    = 1'b1;
                    pidx_next    = agg_cnt_reg[EP_W-1:0];
                    agg_cnt_next = agg_cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    case (cur_st)
                        ST_READY:      any_ready_next = 1'b1;
                        ST_CONNECTING: any_conn_next  = 1'b1;
                        ST_IDLE:
                        begin
                            if (!any_idle_reg)
                            begin
                                first_idle_next = pidx_reg;
                            end
                            any_idle_next = 1'b1;
                        end
                        default:
                        begin
                            if (tf_cnt_reg != 2'd2)
                            begin
                                tf_cnt_next = tf_cnt_reg + 1'b1;
                            end
                        end
                    endcase
                end
                else if (agg_cnt_reg >= ep_len_reg)
                begin
                    res_pend_next.result_kind     = RES_AGG;
                    res_pend_next.aggregate_state = agg_st;
                    if (agg_att && entered_reg && !any_conn_reg && any_idle_reg)
                    begin
                        res_pend_next.connect_request  = 1'b1;
                        res_pend_next.connect_endpoint = first_idle_reg;
                    end
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state, the configuration registers and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ring_len_reg  <= '0;
            ep_len_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.data.idx)
                    CFG_RING_LEN:
                    begin
                        ring_len_reg <= (cfg.data.wdata > CFG_DATA_W'(RING_DEPTH))
                            ? RING_LEN_W'(RING_DEPTH) : cfg.data.wdata[RING_LEN_W-1:0];
                    end
                    CFG_EP_LEN:
                    begin
                        ep_len_reg <= (ep_val > CFG_DATA_W'(MAX_ENDPOINTS))
                            ? EP_LEN_W'(MAX_ENDPOINTS) : ep_val[EP_LEN_W-1:0];
                    end
                    default:
                    begin
                        // drop writes beyond the register list
                    end
                endcase
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        h_reg          <= h_next;
        mv_reg         <= mv_next;
        slot_reg       <= slot_next;
        start_reg      <= start_next;
        wcnt_reg       <= wcnt_next;
        start_own_reg  <= start_own_next;
        own_reg        <= own_next;
        ep_reg         <= ep_next;
        ns_reg         <= ns_next;
        entered_reg    <= entered_next;
        agg_cnt_reg    <= agg_cnt_next;
        pidx_reg       <= pidx_next;
        any_ready_reg  <= any_ready_next;
        any_conn_reg   <= any_conn_next;
        any_idle_reg   <= any_idle_next;
        tf_cnt_reg     <= tf_cnt_next;
        first_idle_reg <= first_idle_next;
        res_pend_reg   <= res_pend_next;
        if (state_reg == S_OUT && out_free)
        begin
            out_reg <= res_pend_reg;
        end
    end

endmodule

// ===== rtl/hrep_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the hash ring endpoint picker, bound to the top level.
// Depends on hrep_pkg and hash_ring_endpoint_picker.
module hrep_checker
    import hrep_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic res_valid,
    input logic res_ready,
    input res_t res_data
);

    // hold a stalled result beat
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    // one item at a time: busy after a request beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // pick fields only on pick beats
    a_pick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.result_kind != RES_PICK |->
        res_data.pick_outcome == PICK_USE && res_data.picked_endpoint == '0 &&
        res_data.start_position == '0)
        else $error("pick fields set on a non-pick beat");

    // a connect request only comes with an aggregate that is neither ready nor idle
    a_conn_req: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.connect_request |->
        res_data.result_kind == RES_AGG && res_data.aggregate_state != ST_READY &&
        res_data.aggregate_state != ST_IDLE)
        else $error("connect request on a wrong beat");

endmodule

bind hash_ring_endpoint_picker hrep_checker u_hrep_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);
